### src/usvg_pkg.sv
package usvg_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SECTOR_COUNT = 2'd0,
        CFG_STACK_COUNT  = 2'd1,
        CFG_RADIUS       = 2'd2
    } cfg_idx_t;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // Result field widths and packing offsets, lowest field first
    localparam int POS_W    = 17;
    localparam int NORM_W   = 16;
    localparam int TEX_W    = 17;
    localparam int OUT_BITS = 3 * POS_W + 3 * NORM_W + 2 * TEX_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam int POS_X_LO  = 0;
    localparam int POS_Y_LO  = POS_X_LO + POS_W;
    localparam int POS_Z_LO  = POS_Y_LO + POS_W;
    localparam int NORM_X_LO = POS_Z_LO + POS_W;
    localparam int NORM_Y_LO = NORM_X_LO + NORM_W;
    localparam int NORM_Z_LO = NORM_Y_LO + NORM_W;
    localparam int TEX_S_LO  = NORM_Z_LO + NORM_W;
    localparam int TEX_T_LO  = TEX_S_LO + TEX_W;

    localparam int POS_LIM  = 65535;
    localparam int NORM_LIM = 16384;
    localparam int TEX_MAX  = 65536;

    // CORDIC datapath: Q2.30 values and phases in 2^-32 turn
    localparam int CW           = 33;
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_X0    = 652032874;

    localparam logic [31:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

endpackage

### src/uv_sphere_vertex_generator_top.sv
// UV sphere vertex generator.
// Input channel (s_): one grid point per transfer, a stack row and a sector
// column. Result channel (m_): position (Q8.8), unit normal (Q1.14) and texture
// coordinates (Q1.16) of that point, one result per input, in order.
// Configuration: cfg_wr_en/cfg_addr/cfg_wdata write sector count, stack count
// and radius; write them only while no item is in flight.
// The pipeline has 22 register stages; one item is taken in every cycle while
// m_ is not stalled. The stages are a clamp stage, 8 stages of long division (4
// quotient bits each), a rounding stage, 8 stages of the two side-by-side CORDIC
// rotators (3 iterations each), then rotation, product, scaling and packing
// stages, each at most one multiplier deep.
// Every stage has a valid bit; a stage loads when it is empty or the stage
// after it moves, so an idle slot anywhere is filled while m_ is stalled, and
// a stall of m_tready holds all occupied stages with nothing lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and restores the
// registers to 36 sectors, 18 stacks and radius 1.0.
module uv_sphere_vertex_generator_top
    import usvg_pkg::*;
#(
    parameter int INDEX_BITS = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // stack_index, sector_index (INDEX_BITS each)
    input  logic [((2*INDEX_BITS+7)/8)*8-1:0] s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_s, tex_t
    output logic [OUT_W-1:0]                  m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]             cfg_addr,
    input  logic [CFG_DATA_W-1:0]             cfg_wdata
);

    localparam int IB          = INDEX_BITS;
    localparam int DIV_BITS    = 32;
    localparam int DIV_PER_ST  = 4;
    localparam int DIV_STAGES  = DIV_BITS / DIV_PER_ST;
    localparam int COR_PER_ST  = 3;
    localparam int COR_STAGES  = CORDIC_STEPS / COR_PER_ST;
    localparam int ST_POST     = DIV_STAGES + 1;
    localparam int ST_COR0     = ST_POST + 1;
    localparam int ST_M1       = ST_COR0 + COR_STAGES;
    localparam int ST_M2       = ST_M1 + 1;
    localparam int ST_M3       = ST_M2 + 1;
    localparam int ST_OUT      = ST_M3 + 1;
    localparam int NST         = ST_OUT + 1;
    localparam int PW          = CW + 17;

    localparam logic signed [2*CW-1:0] RND29  = (2*CW)'(1) <<< 29;
    localparam logic signed [2*CW-1:0] RND45  = (2*CW)'(1) <<< 45;
    localparam logic signed [2*CW-1:0] RND15  = (2*CW)'(1) <<< 15;
    localparam logic signed [PW-1:0]   RNDP29 = PW'(1) <<< 29;

    typedef struct packed {
        logic [IB-1:0] rem_c;
        logic [32:0]   q_c;
        logic          rnd_s;
        logic          rnd_pc;
        logic [IB-1:0] rem_r;
        logic [32:0]   q_r;
        logic          rnd_t;
        logic          rnd_pr;
    } div_t;

    typedef struct packed {
        logic [31:0]      ph_u;
        logic [31:0]      ph_v;
        logic [TEX_W-1:0] tex_s;
        logic [TEX_W-1:0] tex_t;
    } post_t;

    typedef struct packed {
        logic signed [CW-1:0] xu;
        logic signed [CW-1:0] yu;
        logic signed [CW-1:0] zu;
        logic signed [CW-1:0] xv;
        logic signed [CW-1:0] yv;
        logic signed [CW-1:0] zv;
        logic [1:0]           qu;
        logic [1:0]           qv;
        logic [TEX_W-1:0]     tex_s;
        logic [TEX_W-1:0]     tex_t;
    } cor_t;

    typedef struct packed {
        logic signed [2*CW-1:0] pxx;
        logic signed [2*CW-1:0] pyx;
        logic signed [CW-1:0]   su;
        logic [TEX_W-1:0]       tex_s;
        logic [TEX_W-1:0]       tex_t;
    } m1_t;

    typedef struct packed {
        logic signed [CW-1:0]     pxy;
        logic signed [CW-1:0]     pyy;
        logic signed [CW-1:0]     su;
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
        logic [TEX_W-1:0]         tex_s;
        logic [TEX_W-1:0]         tex_t;
    } m2_t;

    typedef struct packed {
        logic signed [PW-1:0]     prx;
        logic signed [PW-1:0]     pry;
        logic signed [PW-1:0]     prz;
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
        logic [TEX_W-1:0]         tex_s;
        logic [TEX_W-1:0]         tex_t;
    } m3_t;

    // One restoring division step on the column axis and, up to step 31, the row axis;
    // flags latch the rounding decision at the bit positions that the outputs need.
    function automatic div_t div_step(div_t d, int k, logic [IB-1:0] sec,
                                      logic [IB-1:0] stk);
        logic [IB:0] rx;
        logic        qb;
        div_t        r;
        r  = d;
        rx = {d.rem_c, 1'b0};
        qb = (rx >= {1'b0, sec});
        r.rem_c = qb ? IB'(rx - {1'b0, sec}) : rx[IB-1:0];
        r.q_c   = {d.q_c[31:0], qb};
        if (k == 16) r.rnd_s = (({1'b0, r.rem_c} + {2'b0, sec[IB-1:1]}) >= {1'b0, sec});
        if (k == 32) r.rnd_pc = (({1'b0, r.rem_c} + {2'b0, sec[IB-1:1]}) >= {1'b0, sec});
        if (k <= 31) begin
            rx = {d.rem_r, 1'b0};
            qb = (rx >= {1'b0, stk});
            r.rem_r = qb ? IB'(rx - {1'b0, stk}) : rx[IB-1:0];
            r.q_r   = {d.q_r[31:0], qb};
            if (k == 16) r.rnd_t = (({1'b0, r.rem_r} + {2'b0, stk[IB-1:1]}) >= {1'b0, stk});
            if (k == 31) r.rnd_pr = (({1'b0, r.rem_r} + {2'b0, stk[IB-1:1]}) >= {1'b0, stk});
        end
        return r;
    endfunction

    // Split a phase into quadrant and residual, and seed the rotators
    function automatic cor_t cor_init(post_t p);
        logic [31:0] tu;
        logic [31:0] tv;
        cor_t        c;
        tu = p.ph_u + 32'h2000_0000;
        tv = p.ph_v + 32'h2000_0000;
        c.qu = tu[31:30];
        c.qv = tv[31:30];
        c.zu = $signed({3'b0, tu[29:0]}) - CW'(32'h2000_0000);
        c.zv = $signed({3'b0, tv[29:0]}) - CW'(32'h2000_0000);
        c.xu = CW'(CORDIC_X0);
        c.xv = CW'(CORDIC_X0);
        c.yu = '0;
        c.yv = '0;
        c.tex_s = p.tex_s;
        c.tex_t = p.tex_t;
        return c;
    endfunction

    function automatic cor_t cor_step(cor_t c, int k);
        logic signed [CW-1:0] at;
        logic signed [CW-1:0] dxu;
        logic signed [CW-1:0] dyu;
        logic signed [CW-1:0] dxv;
        logic signed [CW-1:0] dyv;
        cor_t                 r;
        r   = c;
        at  = $signed({1'b0, ATAN_TURNS[k]});
        dxu = c.yu >>> k;
        dyu = c.xu >>> k;
        dxv = c.yv >>> k;
        dyv = c.xv >>> k;
        if (!c.zu[CW-1]) begin
            r.xu = c.xu - dxu; r.yu = c.yu + dyu; r.zu = c.zu - at;
        end else begin
            r.xu = c.xu + dxu; r.yu = c.yu - dyu; r.zu = c.zu + at;
        end
        if (!c.zv[CW-1]) begin
            r.xv = c.xv - dxv; r.yv = c.yv + dyv; r.zv = c.zv - at;
        end else begin
            r.xv = c.xv + dxv; r.yv = c.yv - dyv; r.zv = c.zv + at;
        end
        return r;
    endfunction

    function automatic logic signed [NORM_W-1:0] sat_norm(logic signed [2*CW-1:0] v);
        if (v > (2*CW)'(NORM_LIM)) return NORM_W'(NORM_LIM);
        if (v < -(2*CW)'(NORM_LIM)) return -NORM_W'(NORM_LIM);
        return v[NORM_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(logic signed [PW-1:0] v);
        if (v > PW'(POS_LIM)) return POS_W'(POS_LIM);
        if (v < -PW'(POS_LIM)) return -POS_W'(POS_LIM);
        return v[POS_W-1:0];
    endfunction

    logic [IB-1:0] sector_count_reg;
    logic [IB-1:0] stack_count_reg;
    logic [15:0]   radius_reg;
    logic [IB-1:0] sec;
    logic [IB-1:0] stk;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_in;
    logic [NST:0]   adv;

    div_t  div_reg  [0:DIV_STAGES];
    div_t  div_next [0:DIV_STAGES];
    post_t post_reg;
    post_t post_next;
    cor_t  cor_reg  [0:COR_STAGES-1];
    cor_t  cor_next [0:COR_STAGES-1];
    m1_t   m1_reg;
    m1_t   m1_next;
    m2_t   m2_reg;
    m2_t   m2_next;
    m3_t   m3_reg;
    m3_t   m3_next;
    logic [OUT_W-1:0] out_reg;
    logic [OUT_W-1:0] out_next;

    // Configuration registers; a zero count acts as one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sector_count_reg <= IB'(36);
            stack_count_reg  <= IB'(18);
            radius_reg       <= 16'd256;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_SECTOR_COUNT: sector_count_reg <= cfg_wdata[IB-1:0];
                CFG_STACK_COUNT:  stack_count_reg  <= cfg_wdata[IB-1:0];
                CFG_RADIUS:       radius_reg       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign sec = (sector_count_reg == '0) ? IB'(1) : sector_count_reg;
    assign stk = (stack_count_reg == '0) ? IB'(1) : stack_count_reg;

    // Stage handshake: load when empty or when the next stage moves
    assign adv[NST] = m_tready;
    for (genvar i = 0; i < NST; i++) begin : g_adv
        assign adv[i] = !vld_reg[i] || adv[i+1];
    end

    // Valid bit that each stage takes from the stage before it
    assign vld_in = {vld_reg[NST-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NST; i++) begin
                if (adv[i]) vld_reg[i] <= vld_in[i];
            end
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = out_reg;

    // Clamp indexes and take the integer quotient bit
    always_comb begin
        logic [IB-1:0] row;
        logic [IB-1:0] col;
        row = s_tdata[IB-1:0];
        col = s_tdata[2*IB-1:IB];
        if (row > stk) row = stk;
        if (col > sec) col = sec;
        div_next[0]        = '0;
        div_next[0].q_c[0] = (col == sec);
        div_next[0].rem_c  = (col == sec) ? '0 : col;
        div_next[0].q_r[0] = (row == stk);
        div_next[0].rem_r  = (row == stk) ? '0 : row;
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) div_reg[0] <= div_next[0];
    end

    // Fractional quotient bits, a few per stage
    for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
        always_comb begin
            div_t d;
            d = div_reg[g-1];
            for (int j = 0; j < DIV_PER_ST; j++) begin
                d = div_step(d, (g - 1) * DIV_PER_ST + j + 1, sec, stk);
            end
            div_next[g] = d;
        end
        always_ff @(posedge aclk) begin
            if (adv[g]) div_reg[g] <= div_next[g];
        end
    end

    // Round quotients into phases and texture coordinates
    always_comb begin
        div_t d;
        d = div_reg[DIV_STAGES];
        post_next.ph_v  = d.q_c[31:0] + 32'(d.rnd_pc);
        post_next.ph_u  = 32'h4000_0000 - (d.q_r[31:0] + 32'(d.rnd_pr));
        post_next.tex_s = d.q_c[32:16] + TEX_W'(d.rnd_s);
        post_next.tex_t = d.q_r[31:15] + TEX_W'(d.rnd_t);
    end

    always_ff @(posedge aclk) begin
        if (adv[ST_POST]) post_reg <= post_next;
    end

    // CORDIC iterations for stack and sector angles side by side
    for (genvar g = 0; g < COR_STAGES; g++) begin : g_cor
        always_comb begin
            cor_t c;
            c = (g == 0) ? cor_init(post_reg) : cor_reg[(g == 0) ? 0 : g - 1];
            for (int j = 0; j < COR_PER_ST; j++) begin
                c = cor_step(c, g * COR_PER_ST + j);
            end
            cor_next[g] = c;
        end
        always_ff @(posedge aclk) begin
            if (adv[ST_COR0 + g]) cor_reg[g] <= cor_next[g];
        end
    end

    // Apply quadrants and form the direction products
    always_comb begin
        cor_t                 c;
        logic signed [CW-1:0] cu;
        logic signed [CW-1:0] su;
        logic signed [CW-1:0] cv;
        logic signed [CW-1:0] sv;
        c = cor_reg[COR_STAGES-1];
        case (c.qu)
            2'd0:    begin cu = c.xu;  su = c.yu;  end
            2'd1:    begin cu = -c.yu; su = c.xu;  end
            2'd2:    begin cu = -c.xu; su = -c.yu; end
            default: begin cu = c.yu;  su = -c.xu; end
        endcase
        case (c.qv)
            2'd0:    begin cv = c.xv;  sv = c.yv;  end
            2'd1:    begin cv = -c.yv; sv = c.xv;  end
            2'd2:    begin cv = -c.xv; sv = -c.yv; end
            default: begin cv = c.yv;  sv = -c.xv; end
        endcase
        m1_next.pxx   = cu * cv;
        m1_next.pyx   = cu * sv;
        m1_next.su    = su;
        m1_next.tex_s = c.tex_s;
        m1_next.tex_t = c.tex_t;
    end

    always_ff @(posedge aclk) begin
        if (adv[ST_M1]) m1_reg <= m1_next;
    end

    // Round products, saturate normals
    always_comb begin
        logic signed [2*CW-1:0] tx;
        logic signed [2*CW-1:0] ty;
        tx = (m1_reg.pxx + RND29) >>> 30;
        ty = (m1_reg.pyx + RND29) >>> 30;
        m2_next.pxy   = tx[CW-1:0];
        m2_next.pyy   = ty[CW-1:0];
        m2_next.su    = m1_reg.su;
        m2_next.nx    = sat_norm((m1_reg.pxx + RND45) >>> 46);
        m2_next.ny    = sat_norm((m1_reg.pyx + RND45) >>> 46);
        m2_next.nz    = sat_norm(((2*CW)'(m1_reg.su) + RND15) >>> 16);
        m2_next.tex_s = m1_reg.tex_s;
        m2_next.tex_t = m1_reg.tex_t;
    end

    always_ff @(posedge aclk) begin
        if (adv[ST_M2]) m2_reg <= m2_next;
    end

    // Scale by radius
    always_comb begin
        logic signed [16:0] rs;
        rs = $signed({1'b0, radius_reg});
        m3_next.prx   = rs * m2_reg.pxy;
        m3_next.pry   = rs * m2_reg.pyy;
        m3_next.prz   = rs * m2_reg.su;
        m3_next.nx    = m2_reg.nx;
        m3_next.ny    = m2_reg.ny;
        m3_next.nz    = m2_reg.nz;
        m3_next.tex_s = m2_reg.tex_s;
        m3_next.tex_t = m2_reg.tex_t;
    end

    always_ff @(posedge aclk) begin
        if (adv[ST_M3]) m3_reg <= m3_next;
    end

    // Round, saturate and pack the result
    always_comb begin
        out_next = '0;
        out_next[POS_X_LO +: POS_W]   = sat_pos((m3_reg.prx + RNDP29) >>> 30);
        out_next[POS_Y_LO +: POS_W]   = sat_pos((m3_reg.pry + RNDP29) >>> 30);
        out_next[POS_Z_LO +: POS_W]   = sat_pos((m3_reg.prz + RNDP29) >>> 30);
        out_next[NORM_X_LO +: NORM_W] = m3_reg.nx;
        out_next[NORM_Y_LO +: NORM_W] = m3_reg.ny;
        out_next[NORM_Z_LO +: NORM_W] = m3_reg.nz;
        out_next[TEX_S_LO +: TEX_W]   = m3_reg.tex_s;
        out_next[TEX_T_LO +: TEX_W]   = m3_reg.tex_t;
    end

    always_ff @(posedge aclk) begin
        if (adv[ST_OUT]) out_reg <= out_next;
    end

endmodule

### src/usvg_checker.sv
module usvg_checker
    import usvg_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // Hold a stalled result
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // Empty pipeline after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Normal z stays within unit range
    a_norm_z: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[NORM_Z_LO +: NORM_W]) <= NORM_W'(NORM_LIM)) &&
                     ($signed(m_tdata[NORM_Z_LO +: NORM_W]) >= -NORM_W'(NORM_LIM)))
        else $error("norm_z out of range");

    // Texture coordinates never exceed one
    a_tex_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[TEX_S_LO +: TEX_W] <= TEX_W'(TEX_MAX)) &&
                     (m_tdata[TEX_T_LO +: TEX_W] <= TEX_W'(TEX_MAX)))
        else $error("texture coordinate out of range");

endmodule

bind uv_sphere_vertex_generator_top usvg_checker u_usvg_checker (.*);

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import usvg_pkg::*;

    localparam int IDX_W       = 12;
    localparam int IN_W        = ((2 * IDX_W + 7) / 8) * 8;
    localparam int LATENCY     = 22;
    localparam int DRAIN_WAIT  = LATENCY + 10;
    localparam int STALL_LIMIT = 20000;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED = 2'd3;

    // one vertex as it sits on m_tdata, highest field first
    typedef struct packed {
        logic [OUT_W-OUT_BITS-1:0] pad;
        logic [TEX_W-1:0]          tex_t;
        logic [TEX_W-1:0]          tex_s;
        logic [NORM_W-1:0]         norm_z;
        logic [NORM_W-1:0]         norm_y;
        logic [NORM_W-1:0]         norm_x;
        logic [POS_W-1:0]          pos_z;
        logic [POS_W-1:0]          pos_y;
        logic [POS_W-1:0]          pos_x;
    } vertex_t;

    typedef struct packed {
        logic [IDX_W-1:0] sector_index;
        logic [IDX_W-1:0] stack_index;
    } grid_pt_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = CFG_SECTOR_COUNT;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    uv_sphere_vertex_generator_top #(.INDEX_BITS(IDX_W)) dut (.*);

    always #4 aclk = ~aclk;

    // shadow registers
    longint sectors_reg = 36;
    longint stacks_reg  = 18;
    longint radius_reg  = 256;

    grid_pt_t pending_pts[$];
    vertex_t  vertex_q[$];
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  errors = 0;
    int  vertices_seen = 0;
    int  quiet_cycles = 0;
    logic s_took = 1'b0;

    function automatic longint rnd_shr(longint v, int k);
        return (v + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // rotation-mode CORDIC on a phase in 2^-32 turn, result in Q2.30
    task automatic turn_sincos(input logic [31:0] ph, output longint c, output longint s);
        logic [1:0]  quad;
        logic [31:0] resid;
        longint x, y, z, dx, dy;
        quad  = 2'((ph + 32'h20000000) >> 30);
        resid = ph - {quad, 30'b0};
        z = longint'($signed(resid));
        x = CORDIC_X0;
        y = 0;
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TURNS[k]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TURNS[k]);
            end
        end
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    task automatic sphere_vertex(input grid_pt_t pt, output vertex_t v);
        longint sectors, stacks, row, col, cu, su, cv, sv, pxy, pyy;
        logic [31:0] ph_sector, ph_stack;
        sectors = (sectors_reg == 0) ? 1 : sectors_reg;
        stacks  = (stacks_reg == 0) ? 1 : stacks_reg;
        row = pt.stack_index;
        col = pt.sector_index;
        if (row > stacks) row = stacks;
        if (col > sectors) col = sectors;
        ph_sector = 32'(((col <<< 32) + (sectors >>> 1)) / sectors);
        ph_stack  = 32'h40000000 - 32'(((row <<< 31) + (stacks >>> 1)) / stacks);
        turn_sincos(ph_stack, cu, su);
        turn_sincos(ph_sector, cv, sv);
        pxy = rnd_shr(cu * cv, 30);
        pyy = rnd_shr(cu * sv, 30);
        v = '0;
        v.pos_x  = POS_W'(clip(rnd_shr(radius_reg * pxy, 30), POS_LIM));
        v.pos_y  = POS_W'(clip(rnd_shr(radius_reg * pyy, 30), POS_LIM));
        v.pos_z  = POS_W'(clip(rnd_shr(radius_reg * su, 30), POS_LIM));
        v.norm_x = NORM_W'(clip(rnd_shr(cu * cv, 46), NORM_LIM));
        v.norm_y = NORM_W'(clip(rnd_shr(cu * sv, 46), NORM_LIM));
        v.norm_z = NORM_W'(clip(rnd_shr(su, 16), NORM_LIM));
        v.tex_s  = TEX_W'((col * 65536 + (sectors >>> 1)) / sectors);
        v.tex_t  = TEX_W'((row * 65536 + (stacks >>> 1)) / stacks);
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // drive the input channel from the pending queue
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || s_took)) begin
            if (pending_pts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_pts.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    // predict on input transfer, check on result transfer, watch for hangs
    always @(posedge aclk) begin
        vertex_t want, got;
        s_took <= s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sphere_vertex(grid_pt_t'(s_tdata), want);
                vertex_q.insert(vertex_q.size(), want);
            end
            if (m_tvalid && m_tready) begin
                vertices_seen++;
                got = m_tdata;
                if (vertex_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected vertex, expected none, actual %h", $time, m_tdata);
                end else begin
                    want = vertex_q.pop_front();
                    check_field("pos_x", want.pos_x, got.pos_x);
                    check_field("pos_y", want.pos_y, got.pos_y);
                    check_field("pos_z", want.pos_z, got.pos_z);
                    check_field("norm_x", want.norm_x, got.norm_x);
                    check_field("norm_y", want.norm_y, got.norm_y);
                    check_field("norm_z", want.norm_z, got.norm_z);
                    check_field("tex_s", want.tex_s, got.tex_s);
                    check_field("tex_t", want.tex_t, got.tex_t);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("uv_sphere_vertex_generator_top verification failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= CFG_DATA_W'(value);
        case (addr)
            CFG_SECTOR_COUNT: sectors_reg = value & 12'hFFF;
            CFG_STACK_COUNT:  stacks_reg  = value & 12'hFFF;
            CFG_RADIUS:       radius_reg  = value & 16'hFFFF;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // wait at rising edges until nothing is queued, offered or in flight
    task automatic drain;
        do @(posedge aclk);
        while (pending_pts.size() != 0 || s_tvalid || vertex_q.size() != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic add_pt(input int row, input int col);
        grid_pt_t pt;
        pt.stack_index  = IDX_W'(row);
        pt.sector_index = IDX_W'(col);
        pending_pts.insert(pending_pts.size(), pt);
    endtask

    // mostly points on or just past the grid, some anywhere in the index range
    task automatic add_random_pts(input int count);
        int row_top, col_top;
        row_top = (stacks_reg + 2 > 4095) ? 4095 : int'(stacks_reg) + 2;
        col_top = (sectors_reg + 2 > 4095) ? 4095 : int'(sectors_reg) + 2;
        repeat (count) begin
            if ($urandom_range(99) < 80)
                add_pt($urandom_range(row_top), $urandom_range(col_top));
            else
                add_pt($urandom_range(4095), $urandom_range(4095));
        end
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
        endcase
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: poles, equator, corners, clamping
        add_pt(0, 0);     add_pt(18, 0);    add_pt(9, 0);     add_pt(9, 9);
        add_pt(9, 18);    add_pt(9, 27);    add_pt(9, 36);    add_pt(19, 37);
        add_pt(4095, 4095); add_pt(0, 4095); add_pt(4095, 0); add_pt(17, 35);
        add_pt(1, 1);     add_pt(2730, 1365); add_pt(1365, 2730); add_pt(4, 5);
        drain();

        // count of zero, count of one, widest counts, zero and full radius
        write_reg(CFG_SECTOR_COUNT, 0);
        write_reg(CFG_STACK_COUNT, 0);
        write_reg(CFG_RADIUS, 0);
        add_pt(0, 0); add_pt(1, 1); add_pt(4095, 4095);
        drain();
        write_reg(CFG_SECTOR_COUNT, 4095);
        write_reg(CFG_STACK_COUNT, 4095);
        write_reg(CFG_RADIUS, 65535);
        write_reg(CFG_UNMAPPED, 16'h0003);
        add_pt(0, 0); add_pt(2047, 1023); add_pt(4095, 4095); add_pt(1, 4094);
        drain();

        // random phases over several settings and idling patterns
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_SECTOR_COUNT, 36); write_reg(CFG_STACK_COUNT, 18);
                    write_reg(CFG_RADIUS, 256);
                end
                1: begin
                    write_reg(CFG_SECTOR_COUNT, 1); write_reg(CFG_STACK_COUNT, 1);
                    write_reg(CFG_RADIUS, 65535);
                end
                2: begin
                    write_reg(CFG_SECTOR_COUNT, 4095); write_reg(CFG_STACK_COUNT, 4095);
                    write_reg(CFG_RADIUS, 1);
                end
                3: begin
                    write_reg(CFG_SECTOR_COUNT, 0); write_reg(CFG_STACK_COUNT, 2);
                    write_reg(CFG_RADIUS, 0);
                end
                default: begin
                    write_reg(CFG_SECTOR_COUNT, $urandom_range(1, 4095));
                    write_reg(CFG_STACK_COUNT, $urandom_range(1, 4095));
                    write_reg(CFG_RADIUS, $urandom_range(65535));
                    if (phase == 6) write_reg(CFG_UNMAPPED, $urandom_range(65535));
                end
            endcase
            for (int chunk = 0; chunk < 4; chunk++) begin
                set_idling((phase + chunk) % 4);
                add_random_pts(48);
                wait (pending_pts.size() == 0);
            end
            drain();
        end

        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("covered %0d vertices over reset, extreme and random sphere settings,",
                 vertices_seen);
        $display("with input gaps and output stalls mixed in every phase");
        if (errors == 0 && vertex_q.size() == 0) begin
            $display("uv_sphere_vertex_generator_top verification clean");
        end else begin
            $display("%0d mismatches, %0d vertices never returned", errors, vertex_q.size());
            $display("uv_sphere_vertex_generator_top verification failed");
        end
        $finish;
    end
endmodule
